>>> rtl/lrts_pkg.sv
// ============================================================================
// lrts_pkg
// Shared types and constants of the longest-remaining-time scheduler.
// ============================================================================
package lrts_pkg;

    localparam int ID_W    = 16;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 19;
    localparam int ELAP_W  = 20;

    localparam logic [ELAP_W-1:0] ELAPSED_MAX  = 20'hFFFFF;
    localparam logic [TIME_W-1:0] TIME_OUT_MAX = 19'h7FFFF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [ID_W-1:0]    job_id;
        logic [BURST_W-1:0] burst;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   served_id;
        logic              idle;
        logic              finished;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
    } out_item_t;

    // One table entry as it sits in the job memory.
    typedef struct packed {
        logic [ID_W-1:0]    job_id;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
    } job_word_t;

    localparam int JOB_WORD_W = $bits(job_word_t);

    // Control from the sequencer to the maximum picker.
    typedef struct packed {
        logic clear;
        logic sample;
    } pick_ctl_t;

endpackage

>>> rtl/lrts_stream_if.sv
// ============================================================================
// lrts_stream_if
// Valid/ready channel carrying one item of payload type T.
// ============================================================================
interface lrts_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lrts_ram.sv
// ============================================================================
// lrts_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module lrts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/lrts_pick.sv
// ============================================================================
// lrts_pick
// Running maximum over the entries streamed out of the job memory.
// ============================================================================
module lrts_pick
    import lrts_pkg::*;
#(
    parameter int IDX_W = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pick_ctl_t        ctl,
    input  job_word_t        word,
    input  logic [IDX_W-1:0] word_idx,
    output logic             found,
    output job_word_t        best,
    output logic [IDX_W-1:0] best_idx
);

    logic             found_reg, found_next;
    job_word_t        best_reg, best_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             take;

    // A later slot wins only on strictly more time, or equal time and lower id,
    // so ties on both keep the earlier slot.
    always_comb
    begin
        take = (word.remaining != '0) &&
               (!found_reg ||
                (word.remaining > best_reg.remaining) ||
                ((word.remaining == best_reg.remaining) &&
                 (word.job_id < best_reg.job_id)));
        found_next = found_reg;
        best_next  = best_reg;
        idx_next   = idx_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctl.sample && take)
        begin
            found_next = 1'b1;
            best_next  = word;
            idx_next   = word_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        idx_reg  <= idx_next;
    end

    assign found    = found_reg;
    assign best     = best_reg;
    assign best_idx = idx_reg;

endmodule

>>> rtl/longest_remaining_time_scheduler_core.sv
// ============================================================================
// longest_remaining_time_scheduler_core
// Preemptive longest-remaining-time-first scheduler over a job memory.
// ============================================================================
// A load item gives no result. A tick item reads the filled slots of the job
// memory, one entry per cycle, then passes through ST_LAST to ST_RESULT, where
// it waits until the output register is free before its result is registered.
// One item at a time: a new request is taken only in the idle state.
// Reset: asynchronous, active low; clears the fill count, elapsed time and
// control. The job memory needs no clearing since only filled slots are read.
// ============================================================================
module longest_remaining_time_scheduler_core
    import lrts_pkg::*;
#(
    parameter int NUM_JOBS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    lrts_stream_if.sink   request,
    lrts_stream_if.source response
);

    localparam int IDX_W = $clog2(NUM_JOBS);
    localparam int CNT_W = $clog2(NUM_JOBS + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(NUM_JOBS);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_LAST   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic [ELAP_W-1:0] elapsed_reg, elapsed_next;
    logic              out_vld_reg, out_vld_next;
    out_item_t         out_reg, out_next;

    in_item_t          req;
    logic              req_fire;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    job_word_t         wr_word;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    job_word_t         rd_word;

    pick_ctl_t         pick_ctl;
    logic              best_found;
    job_word_t         best_word;
    logic [IDX_W-1:0]  best_idx;

    logic              out_free;
    logic [BURST_W-1:0] new_rem;
    logic [ELAP_W-1:0] elapsed_inc;
    logic [TIME_W-1:0] ta;
    logic [TIME_W-1:0] burst_ext;

    assign req           = request.data;
    assign request.ready = (state_reg == ST_IDLE);
    assign req_fire      = request.valid && request.ready;

    assign response.valid = out_vld_reg;
    assign response.data  = out_reg;

    // The output register can take a new item when it is empty or being drained.
    assign out_free = !out_vld_reg || response.ready;

    lrts_ram #(
        .WIDTH (JOB_WORD_W),
        .DEPTH (NUM_JOBS)
    ) u_job_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    lrts_pick #(
        .IDX_W (IDX_W)
    ) u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (pick_ctl),
        .word     (rd_word),
        .word_idx (pend_idx_reg),
        .found    (best_found),
        .best     (best_word),
        .best_idx (best_idx)
    );

    // Result arithmetic for the chosen job. Elapsed time saturates at its own
    // limit, turnaround at the narrower output limit, and waiting floors at zero.
    always_comb
    begin
        new_rem     = best_word.remaining - BURST_W'(1);
        elapsed_inc = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + ELAP_W'(1) : elapsed_reg;
        ta          = (elapsed_inc > ELAP_W'(TIME_OUT_MAX)) ? TIME_OUT_MAX
                                                           : elapsed_inc[TIME_W-1:0];
        burst_ext   = TIME_W'(best_word.burst);
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        issue_next   = issue_reg;
        pend_next    = 1'b0;
        elapsed_next = elapsed_reg;
        out_vld_next = out_vld_reg && !response.ready;
        out_next     = out_reg;

        wr_en        = 1'b0;
        wr_addr      = count_reg[IDX_W-1:0];
        wr_word      = '{job_id: req.job_id, burst: req.burst, remaining: req.burst};
        rd_en        = 1'b0;
        rd_addr      = issue_reg[IDX_W-1:0];
        pick_ctl     = '{clear: 1'b0, sample: pend_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.operation == OP_LOAD)
                    begin
                        // A load past the last slot is dropped.
                        if (count_reg < FULL_COUNT)
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        pick_ctl.clear = 1'b1;
                        issue_next     = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // One read per cycle over the filled slots; the data reaches
                // the picker in the cycle after its read.
                if (issue_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    pend_next  = 1'b1;
                    issue_next = issue_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                // The final read was folded into the picker in the last scan
                // cycle, so the choice is already held here.
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    out_next     = '0;
                    if (best_found)
                    begin
                        wr_en              = 1'b1;
                        wr_addr            = best_idx;
                        wr_word            = best_word;
                        wr_word.remaining  = new_rem;
                        elapsed_next       = elapsed_inc;
                        out_next.served_id = best_word.job_id;
                        if (new_rem == '0)
                        begin
                            out_next.finished   = 1'b1;
                            out_next.turnaround = ta;
                            out_next.waiting    = (ta >= burst_ext) ? ta - burst_ext : '0;
                        end
                    end
                    else
                    begin
                        out_next.idle = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            issue_reg   <= '0;
            pend_reg    <= 1'b0;
            elapsed_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            elapsed_reg <= elapsed_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        pend_idx_reg <= rd_addr;
    end

endmodule
